// ===== rtl/assert_macros.svh =====
// Assertion macros used by the checker file of this block.
// Each macro expects signals named aclk and aresetn in the enclosing scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PPH_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("same-cycle implication failed");

// Next-cycle implication, disabled while reset is asserted.
`define PPH_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("next-cycle implication failed");

`endif

// ===== rtl/pph_pkg.sv =====
// Shared widths, constants and types of the point pair feature hash.
// Used by pph_unit, point_pair_feature_hash and pph_checker; depends on nothing.
package pph_pkg;

    // Field widths of the stream items and registers.
    localparam int POS_W      = 24;
    localparam int NRM_W      = 16;
    localparam int STEP_W     = 32;
    localparam int DBIN_W     = 10;
    localparam int HASH_W     = 28;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 32;
    localparam int IN_DATA_W  = 144;
    localparam int OUT_DATA_W = 32;

    // Vector normalization datapath.
    localparam int VEC_W     = POS_W + 1;
    localparam int MAG_W     = VEC_W;
    localparam int SQ_W      = 2 * MAG_W;
    localparam int SUM_W     = SQ_W + 2;
    localparam int MSB_W     = 6;
    localparam int ROOT_W    = 64;
    localparam int ROOT_MIN_MSB = 60;
    localparam int LEN_W     = 31;
    localparam int M_W       = 31;
    localparam int FRAC_W    = 24;
    localparam int DIV_STEPS = 25;
    localparam int Q_W       = DIV_STEPS;
    localparam int UNIT_W    = Q_W + 1;
    localparam int SH_W      = 5;
    localparam int REM_W     = LEN_W + 1;
    localparam int NUM_W     = M_W + FRAC_W + 1;
    localparam int SQ_STEPS  = 32;
    localparam int UNIT_LAT  = 5 + SQ_STEPS + 1 + DIV_STEPS + 1;

    // Feature and hash datapath.
    localparam int PROD_W  = 2 * UNIT_W;
    localparam int COS_W   = PROD_W + 2;
    localparam int DPROD_W = 64;
    localparam int DQ_W    = 32;
    localparam int IDX_SHIFT = 49;
    localparam longint Q48_ONE    = 64'sd281474976710656;
    localparam longint COS_THRESH = 64'sd281472161960889;

    // Angle table.
    localparam int COS_RESOLUTION = 1024;
    localparam int ANGLE_BINS     = 32;
    localparam int TBL_DEPTH      = COS_RESOLUTION + 1;
    localparam int IDX_W          = $clog2(TBL_DEPTH);
    localparam int BIN_W          = 7;

    // Operation carried in tuser of an input request.
    typedef enum logic {
        FUNC_LOAD = 1'b0,
        FUNC_HASH = 1'b1
    } func_t;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_REF_POS_X  = 4'd0,
        REG_REF_POS_Y  = 4'd1,
        REG_REF_POS_Z  = 4'd2,
        REG_REF_NORM_X = 4'd3,
        REG_REF_NORM_Y = 4'd4,
        REG_REF_NORM_Z = 4'd5,
        REG_INV_STEP   = 4'd6,
        REG_DIST_BINS  = 4'd7
    } cfg_reg_t;

    // Result of one vector normalization unit.
    typedef struct packed {
        logic                         nonzero;
        logic [SH_W-1:0]              shift;
        logic [LEN_W-1:0]             len;
        logic [2:0][UNIT_W-1:0]       u;
    } unit_res_t;

    // Control that travels along the pipeline with each request.
    typedef struct packed {
        logic             valid;
        logic             hash_op;
        logic [IDX_W-1:0] tidx;
        logic [BIN_W-1:0] tval;
    } side_t;

endpackage

// ===== rtl/pph_unit.sv =====
// Pipelined normalization of one 3-vector to a Q.24 unit vector, with length and scale.
// Depends on pph_pkg.
module pph_unit (
    input  logic                             aclk,
    input  logic                             en,
    input  logic signed [pph_pkg::VEC_W-1:0] vec [3],
    output pph_pkg::unit_res_t               res
);

    typedef struct packed {
        logic [2:0]                          neg;
        logic                                nz;
        logic [pph_pkg::SH_W-1:0]            sh;
        logic [2:0][pph_pkg::M_W-1:0]        m;
    } uside_t;

    logic [pph_pkg::MAG_W-1:0]  mag_reg [4][3];
    logic [2:0]                 neg_reg [4];
    logic [pph_pkg::SQ_W-1:0]   sqp_reg [3];
    logic [pph_pkg::SUM_W-1:0]  sum_reg [2];
    logic [pph_pkg::SH_W-1:0]   sh3_reg;
    logic                       nz3_reg;

    logic [pph_pkg::ROOT_W-1:0] x_reg  [pph_pkg::SQ_STEPS+1];
    logic [pph_pkg::ROOT_W-1:0] r_reg  [pph_pkg::SQ_STEPS+1];
    logic [pph_pkg::ROOT_W-1:0] x_next [pph_pkg::SQ_STEPS+1];
    logic [pph_pkg::ROOT_W-1:0] r_next [pph_pkg::SQ_STEPS+1];
    uside_t                     sside_reg  [pph_pkg::SQ_STEPS+1];
    uside_t                     sside0_next;

    uside_t                     dside_reg [pph_pkg::DIV_STEPS+1];
    logic [pph_pkg::LEN_W-1:0]  l_reg     [pph_pkg::DIV_STEPS+1];
    logic [pph_pkg::LEN_W-1:0]  rem_reg   [pph_pkg::DIV_STEPS+1][3];
    logic [pph_pkg::DIV_STEPS-1:0] nb_reg [pph_pkg::DIV_STEPS+1][3];
    logic [pph_pkg::Q_W-1:0]    q_reg     [pph_pkg::DIV_STEPS+1][3];
    logic [pph_pkg::LEN_W-1:0]  rem_next  [pph_pkg::DIV_STEPS+1][3];
    logic [pph_pkg::DIV_STEPS-1:0] nb_next [pph_pkg::DIV_STEPS+1][3];
    logic [pph_pkg::Q_W-1:0]    q_next    [pph_pkg::DIV_STEPS+1][3];

    logic [pph_pkg::SH_W-1:0]   sh3_next;
    pph_pkg::unit_res_t         res_reg;
    pph_pkg::unit_res_t         res_next;

    // Leading one search on the squared length picks the even scale 4^s.
    always_comb begin
        logic [pph_pkg::MSB_W-1:0] msb;
        msb = '0;
        for (int b = 0; b < pph_pkg::SUM_W; b++) begin
            if (sum_reg[0][b]) msb = pph_pkg::MSB_W'(b);
        end
        sh3_next = pph_pkg::SH_W'((pph_pkg::ROOT_MIN_MSB + 1 - int'(msb)) >> 1);
    end

    // Scaled square and components enter the square root chain, then one
    // restoring square root step per stage.
    always_comb begin
        logic [pph_pkg::ROOT_W-1:0] bitv;
        logic [pph_pkg::ROOT_W-1:0] t;
        x_next[0] = pph_pkg::ROOT_W'(sum_reg[1]) << {sh3_reg, 1'b0};
        r_next[0] = '0;
        sside0_next.neg = neg_reg[3];
        sside0_next.nz  = nz3_reg;
        sside0_next.sh  = sh3_reg;
        for (int i = 0; i < 3; i++) begin
            sside0_next.m[i] = pph_pkg::M_W'(mag_reg[3][i]) << sh3_reg;
        end
        for (int k = 0; k < pph_pkg::SQ_STEPS; k++) begin
            bitv = pph_pkg::ROOT_W'(1) << (pph_pkg::ROOT_W - 2 - 2 * k);
            t    = r_reg[k] + bitv;
            if (x_reg[k] >= t) begin
                x_next[k+1] = x_reg[k] - t;
                r_next[k+1] = (r_reg[k] >> 1) + bitv;
            end else begin
                x_next[k+1] = x_reg[k];
                r_next[k+1] = r_reg[k] >> 1;
            end
        end
    end

    // Divider setup: numerator is m * 2^24 plus half the length for rounding.
    // Then one restoring division step per stage for all three components.
    always_comb begin
        logic [pph_pkg::NUM_W-1:0] num;
        logic [pph_pkg::LEN_W-1:0] l;
        logic [pph_pkg::REM_W-1:0] trial;
        l = r_reg[pph_pkg::SQ_STEPS][pph_pkg::LEN_W-1:0];
        for (int i = 0; i < 3; i++) begin
            num = (pph_pkg::NUM_W'(sside_reg[pph_pkg::SQ_STEPS].m[i]) << pph_pkg::FRAC_W)
                + pph_pkg::NUM_W'(l >> 1);
            rem_next[0][i] = pph_pkg::LEN_W'(num >> pph_pkg::DIV_STEPS);
            nb_next[0][i]  = num[pph_pkg::DIV_STEPS-1:0];
            q_next[0][i]   = '0;
        end
        for (int j = 0; j < pph_pkg::DIV_STEPS; j++) begin
            for (int i = 0; i < 3; i++) begin
                trial = {rem_reg[j][i], nb_reg[j][i][pph_pkg::DIV_STEPS-1]};
                nb_next[j+1][i] = nb_reg[j][i] << 1;
                if (trial >= {1'b0, l_reg[j]}) begin
                    rem_next[j+1][i] = pph_pkg::LEN_W'(trial - {1'b0, l_reg[j]});
                    q_next[j+1][i]   = {q_reg[j][i][pph_pkg::Q_W-2:0], 1'b1};
                end else begin
                    rem_next[j+1][i] = pph_pkg::LEN_W'(trial);
                    q_next[j+1][i]   = {q_reg[j][i][pph_pkg::Q_W-2:0], 1'b0};
                end
            end
        end
    end

    // Sign restore and result assembly.
    always_comb begin
        logic signed [pph_pkg::UNIT_W-1:0] qs;
        res_next.nonzero = dside_reg[pph_pkg::DIV_STEPS].nz;
        res_next.shift   = dside_reg[pph_pkg::DIV_STEPS].sh;
        res_next.len     = l_reg[pph_pkg::DIV_STEPS];
        for (int i = 0; i < 3; i++) begin
            qs = $signed({1'b0, q_reg[pph_pkg::DIV_STEPS][i]});
            res_next.u[i] = dside_reg[pph_pkg::DIV_STEPS].neg[i] ? -qs : qs;
        end
    end

    // Stage registers, all advancing together.
    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                mag_reg[0][i] <= vec[i][pph_pkg::VEC_W-1] ? pph_pkg::MAG_W'(-vec[i])
                                                          : pph_pkg::MAG_W'(vec[i]);
                neg_reg[0][i] <= vec[i][pph_pkg::VEC_W-1];
                sqp_reg[i]    <= mag_reg[0][i] * mag_reg[0][i];
            end
            for (int s = 1; s < 4; s++) begin
                mag_reg[s] <= mag_reg[s-1];
                neg_reg[s] <= neg_reg[s-1];
            end
            sum_reg[0] <= pph_pkg::SUM_W'(sqp_reg[0]) + pph_pkg::SUM_W'(sqp_reg[1])
                        + pph_pkg::SUM_W'(sqp_reg[2]);
            sum_reg[1] <= sum_reg[0];
            sh3_reg    <= sh3_next;
            nz3_reg    <= (sum_reg[0] != '0);

            sside_reg[0] <= sside0_next;
            for (int k = 0; k <= pph_pkg::SQ_STEPS; k++) begin
                x_reg[k] <= x_next[k];
                r_reg[k] <= r_next[k];
            end
            for (int k = 1; k <= pph_pkg::SQ_STEPS; k++) begin
                sside_reg[k] <= sside_reg[k-1];
            end

            dside_reg[0] <= sside_reg[pph_pkg::SQ_STEPS];
            l_reg[0]     <= r_reg[pph_pkg::SQ_STEPS][pph_pkg::LEN_W-1:0];
            for (int j = 1; j <= pph_pkg::DIV_STEPS; j++) begin
                dside_reg[j] <= dside_reg[j-1];
                l_reg[j]     <= l_reg[j-1];
            end
            for (int j = 0; j <= pph_pkg::DIV_STEPS; j++) begin
                for (int i = 0; i < 3; i++) begin
                    rem_reg[j][i] <= rem_next[j][i];
                    nb_reg[j][i]  <= nb_next[j][i];
                    q_reg[j][i]   <= q_next[j][i];
                end
            end
            res_reg <= res_next;
        end
    end

    assign res = res_reg;

endmodule

// ===== rtl/point_pair_feature_hash.sv =====
// Top level of the point pair feature hash: config registers, three normalization
// units, feature dot products, angle table lookup and hash packing. Depends on pph_pkg, pph_unit.
//
// Channel   Direction  Handshake                    Payload
// s_axis    in         s_axis_tvalid/s_axis_tready  tdata: point, normal, table entry; tuser: func
// m_axis    out        m_axis_tvalid/m_axis_tready  tdata: hash; tuser: degenerate
// cfg       in         cfg_valid/cfg_ready          cfg_index, cfg_data
//
// One request is accepted per cycle unless the output is stalled; a hash result passes through
// the 32-stage square root and the 25-stage divider of the normalization units.
// Table loads travel the same pipeline and produce no result.
// A stalled output register holds the whole pipeline; s_axis_tready follows it.
// aresetn is synchronous and active low; it clears all valid bits and sets the config registers to their defaults.
module point_pair_feature_hash (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // pos_x[23:0] pos_y[47:24] pos_z[71:48] norm_x[87:72] norm_y[103:88]
    // norm_z[119:104] table_index[130:120] table_value[137:131], zeros above
    input  logic [pph_pkg::IN_DATA_W-1:0]       s_axis_tdata,
    // func[0]
    input  logic [0:0]                          s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // hash[27:0], zeros above
    output logic [pph_pkg::OUT_DATA_W-1:0]      m_axis_tdata,
    // degenerate[0]
    output logic [0:0]                          m_axis_tuser,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [pph_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [pph_pkg::CFG_DATA_W-1:0]      cfg_data
);

    logic signed [pph_pkg::POS_W-1:0] ref_pos_reg  [3];
    logic signed [pph_pkg::NRM_W-1:0] ref_norm_reg [3];
    logic [pph_pkg::STEP_W-1:0]       inv_step_reg;
    logic [pph_pkg::DBIN_W-1:0]       dist_bins_reg;

    logic en;

    logic signed [pph_pkg::VEC_W-1:0] d_reg  [3];
    logic signed [pph_pkg::VEC_W-1:0] n1_reg [3];
    logic signed [pph_pkg::VEC_W-1:0] n2_reg [3];
    pph_pkg::side_t side_reg [pph_pkg::UNIT_LAT+1];

    pph_pkg::unit_res_t res_d, res_1, res_2;

    logic signed [pph_pkg::PROD_W-1:0] prod_reg [3][3];
    logic [pph_pkg::DPROD_W-1:0]       dprod_reg;
    logic [pph_pkg::SH_W-1:0]          sh1_reg;
    logic                              ok1_reg;
    pph_pkg::side_t                    p1_side_reg;

    logic signed [pph_pkg::COS_W-1:0]  cos_reg [3];
    logic [pph_pkg::DQ_W-1:0]          dist_reg;
    logic [pph_pkg::DQ_W-1:0]          dist_next;
    logic                              ok2_reg;
    pph_pkg::side_t                    p2_side_reg;

    logic [pph_pkg::IDX_W-1:0]         idx_reg  [3];
    logic [pph_pkg::IDX_W-1:0]         idx_next [3];
    logic [pph_pkg::DBIN_W-1:0]        dbin_reg;
    logic [pph_pkg::DBIN_W-1:0]        dbin_next;
    logic                              ok3_reg;
    pph_pkg::side_t                    p3_side_reg;

    logic [pph_pkg::BIN_W-1:0]         rd_reg [3];
    logic [pph_pkg::DBIN_W-1:0]        dbin4_reg;
    logic                              ok4_reg;
    pph_pkg::side_t                    p4_side_reg;
    logic                              tbl_we;

    logic                              m_valid_reg;
    logic [pph_pkg::HASH_W-1:0]        hash_reg;
    logic [pph_pkg::HASH_W-1:0]        hash_next;
    logic                              degen_reg;

    // The whole pipeline advances whenever the output register can take a result.
    assign en            = !m_valid_reg || m_axis_tready;
    assign s_axis_tready = en;
    assign cfg_ready     = 1'b1;

    // Configuration registers; writes beyond the last index are dropped.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 3; i++) begin
                ref_pos_reg[i]  <= '0;
                ref_norm_reg[i] <= '0;
            end
            ref_norm_reg[2] <= pph_pkg::NRM_W'(16384);
            inv_step_reg    <= pph_pkg::STEP_W'(65536);
            dist_bins_reg   <= pph_pkg::DBIN_W'(64);
        end else if (cfg_valid) begin
            case (pph_pkg::cfg_reg_t'(cfg_index))
                pph_pkg::REG_REF_POS_X:  ref_pos_reg[0]  <= cfg_data[pph_pkg::POS_W-1:0];
                pph_pkg::REG_REF_POS_Y:  ref_pos_reg[1]  <= cfg_data[pph_pkg::POS_W-1:0];
                pph_pkg::REG_REF_POS_Z:  ref_pos_reg[2]  <= cfg_data[pph_pkg::POS_W-1:0];
                pph_pkg::REG_REF_NORM_X: ref_norm_reg[0] <= cfg_data[pph_pkg::NRM_W-1:0];
                pph_pkg::REG_REF_NORM_Y: ref_norm_reg[1] <= cfg_data[pph_pkg::NRM_W-1:0];
                pph_pkg::REG_REF_NORM_Z: ref_norm_reg[2] <= cfg_data[pph_pkg::NRM_W-1:0];
                pph_pkg::REG_INV_STEP:   inv_step_reg    <= cfg_data[pph_pkg::STEP_W-1:0];
                pph_pkg::REG_DIST_BINS:  dist_bins_reg   <= cfg_data[pph_pkg::DBIN_W-1:0];
                default: ;
            endcase
        end
    end

    // Entry stage: direction vector and both normals, sign-extended.
    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                d_reg[i] <= pph_pkg::VEC_W'($signed(
                                s_axis_tdata[i*pph_pkg::POS_W +: pph_pkg::POS_W]))
                          - pph_pkg::VEC_W'(ref_pos_reg[i]);
                n1_reg[i] <= pph_pkg::VEC_W'(ref_norm_reg[i]);
                n2_reg[i] <= pph_pkg::VEC_W'($signed(
                                s_axis_tdata[3*pph_pkg::POS_W + i*pph_pkg::NRM_W +:
                                             pph_pkg::NRM_W]));
            end
        end
    end

    // Request control rides alongside the normalization units.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k <= pph_pkg::UNIT_LAT; k++) side_reg[k].valid <= 1'b0;
            p1_side_reg.valid <= 1'b0;
            p2_side_reg.valid <= 1'b0;
            p3_side_reg.valid <= 1'b0;
            p4_side_reg.valid <= 1'b0;
        end else if (en) begin
            side_reg[0].valid   <= s_axis_tvalid;
            side_reg[0].hash_op <= (pph_pkg::func_t'(s_axis_tuser[0]) == pph_pkg::FUNC_HASH);
            side_reg[0].tidx    <= s_axis_tdata[120 +: pph_pkg::IDX_W];
            side_reg[0].tval    <= s_axis_tdata[131 +: pph_pkg::BIN_W];
            for (int k = 1; k <= pph_pkg::UNIT_LAT; k++) side_reg[k] <= side_reg[k-1];
            p1_side_reg <= side_reg[pph_pkg::UNIT_LAT];
            p2_side_reg <= p1_side_reg;
            p3_side_reg <= p2_side_reg;
            p4_side_reg <= p3_side_reg;
        end
    end

    pph_unit u_unit_d  (.aclk(aclk), .en(en), .vec(d_reg),  .res(res_d));
    pph_unit u_unit_n1 (.aclk(aclk), .en(en), .vec(n1_reg), .res(res_1));
    pph_unit u_unit_n2 (.aclk(aclk), .en(en), .vec(n2_reg), .res(res_2));

    // Products for the three dot products and the scaled distance.
    always_ff @(posedge aclk) begin
        if (en) begin
            for (int j = 0; j < 3; j++) begin
                prod_reg[0][j] <= $signed(res_1.u[j]) * $signed(res_d.u[j]);
                prod_reg[1][j] <= $signed(res_2.u[j]) * $signed(res_d.u[j]);
                prod_reg[2][j] <= $signed(res_1.u[j]) * $signed(res_2.u[j]);
            end
            dprod_reg <= pph_pkg::DPROD_W'(res_d.len) * pph_pkg::DPROD_W'(inv_step_reg);
            sh1_reg   <= res_d.shift;
            ok1_reg   <= res_d.nonzero && res_1.nonzero && res_2.nonzero;
        end
    end

    // Rounded distance, undoing the normalization scale.
    always_comb begin
        logic [pph_pkg::DPROD_W-1:0] rnd;
        rnd       = pph_pkg::DPROD_W'(1) << (31 + int'(sh1_reg));
        dist_next = pph_pkg::DQ_W'((dprod_reg + rnd) >> (32 + int'(sh1_reg)));
    end

    // Dot product sums.
    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < 3; k++) begin
                cos_reg[k] <= pph_pkg::COS_W'(prod_reg[k][0]) + pph_pkg::COS_W'(prod_reg[k][1])
                            + pph_pkg::COS_W'(prod_reg[k][2]);
            end
            dist_reg <= dist_next;
            ok2_reg  <= ok1_reg;
        end
    end

    // Cosine clamp, table index and distance bin saturation.
    always_comb begin
        logic signed [63:0] cw;
        logic [63:0]        off;
        logic [63:0]        scaled;
        logic [63:0]        idxw;
        logic [pph_pkg::DBIN_W-1:0] maxd;
        for (int k = 0; k < 3; k++) begin
            cw = 64'(cos_reg[k]);
            if (cw < -pph_pkg::COS_THRESH) begin
                cw = -pph_pkg::Q48_ONE;
            end else if (cw >= pph_pkg::COS_THRESH) begin
                cw = pph_pkg::Q48_ONE;
            end
            off    = 64'(cw + pph_pkg::Q48_ONE);
            scaled = off * 64'(pph_pkg::COS_RESOLUTION) + 64'(pph_pkg::Q48_ONE);
            idxw   = scaled >> pph_pkg::IDX_SHIFT;
            if (idxw > 64'(pph_pkg::TBL_DEPTH - 1)) idxw = 64'(pph_pkg::TBL_DEPTH - 1);
            idx_next[k] = pph_pkg::IDX_W'(idxw);
        end
        maxd = (dist_bins_reg == '0) ? '0 : dist_bins_reg - 1'b1;
        if (dist_reg > pph_pkg::DQ_W'(maxd)) begin
            dbin_next = maxd;
        end else begin
            dbin_next = pph_pkg::DBIN_W'(dist_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            idx_reg  <= idx_next;
            dbin_reg <= dbin_next;
            ok3_reg  <= ok2_reg;
            dbin4_reg <= dbin_reg;
            ok4_reg   <= ok3_reg;
        end
    end

    // Table loads are written at the same stage where hashes read, keeping request order.
    assign tbl_we = en && p3_side_reg.valid && !p3_side_reg.hash_op
                 && (p3_side_reg.tidx <= pph_pkg::IDX_W'(pph_pkg::COS_RESOLUTION));

    // Three copies of the angle table, one per cosine.
    for (genvar k = 0; k < 3; k++) begin : g_tbl
        logic [pph_pkg::BIN_W-1:0] tbl_mem [pph_pkg::TBL_DEPTH];
        always_ff @(posedge aclk) begin
            if (en) begin
                if (tbl_we) tbl_mem[p3_side_reg.tidx] <= p3_side_reg.tval;
                rd_reg[k] <= tbl_mem[idx_reg[k]];
            end
        end
    end

    // Bin saturation and hash packing.
    always_comb begin
        logic [63:0] b [3];
        logic [63:0] h;
        for (int k = 0; k < 3; k++) begin
            b[k] = (32'(rd_reg[k]) >= pph_pkg::ANGLE_BINS) ? 64'(pph_pkg::ANGLE_BINS - 1)
                                                            : 64'(rd_reg[k]);
        end
        h = b[0] + b[1] * 64'(pph_pkg::ANGLE_BINS)
          + b[2] * 64'(pph_pkg::ANGLE_BINS * pph_pkg::ANGLE_BINS)
          + 64'(dbin4_reg) * 64'(pph_pkg::ANGLE_BINS * pph_pkg::ANGLE_BINS
                                 * pph_pkg::ANGLE_BINS);
        hash_next = ok4_reg ? pph_pkg::HASH_W'(h) : '0;
    end

    // Output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= p4_side_reg.valid && p4_side_reg.hash_op;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            hash_reg  <= hash_next;
            degen_reg <= !ok4_reg;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = pph_pkg::OUT_DATA_W'(hash_reg);
    assign m_axis_tuser  = degen_reg;

endmodule

// ===== rtl/pph_checker.sv =====
// Port-level checks of the point pair feature hash, bound to the top level.
// Depends on assert_macros.svh and pph_pkg.
`include "assert_macros.svh"

module pph_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_axis_tready,
    input logic                           m_axis_tvalid,
    input logic                           m_axis_tready,
    input logic [pph_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    input logic [0:0]                     m_axis_tuser
);

    // A degenerate pair always reports a zero hash.
    `PPH_ASSERT_IMP(a_degen_zero, m_axis_tvalid && m_axis_tuser[0], m_axis_tdata == '0)

    // Bits above the hash are always zero.
    `PPH_ASSERT_IMP(a_pad_zero, m_axis_tvalid, (m_axis_tdata >> pph_pkg::HASH_W) == '0)

    // An empty output register never blocks new requests.
    `PPH_ASSERT_IMP(a_ready_when_empty, !m_axis_tvalid, s_axis_tready)

    // A stalled result holds its value.
    `PPH_ASSERT_NXT(a_hold, m_axis_tvalid && !m_axis_tready,
        m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))

endmodule

bind point_pair_feature_hash pph_checker u_pph_checker (.*);
